### rtl/lnc_pkg.sv
`timescale 1ns / 1ps
package lnc_pkg;

	localparam int LEN_W   = 22;
	localparam int ENV_W   = 20;
	localparam int PH_W    = 24;
	localparam int ALU_W   = 24;
	localparam int LFSR_W  = 15;
	localparam int DT_W    = 9;
	localparam int VOL_W   = 4;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [LFSR_W-1:0] LFSR_RESET = 15'h7FFF;
	localparam logic [VOL_W-1:0]  VOL_MAX    = 4'hF;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_TRIGGER = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		REG_LENGTH_LOAD       = 3'd0,
		REG_LENGTH_ENABLE     = 3'd1,
		REG_START_VOLUME      = 3'd2,
		REG_ENVELOPE_INCREASE = 3'd3,
		REG_ENVELOPE_PERIOD   = 3'd4,
		REG_CLOCK_SHIFT       = 3'd5,
		REG_NARROW_MODE       = 3'd6,
		REG_DIVISOR_CODE      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [5:0] length_load;
		logic       length_enable;
		logic [3:0] start_volume;
		logic       envelope_increase;
		logic [2:0] envelope_period;
		logic [3:0] clock_shift;
		logic       narrow_mode;
		logic [2:0] divisor_code;
	} cfg_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] cycles;
		logic       double_speed;
	} cmd_t;

	typedef struct packed {
		logic signed [4:0] sample;
		logic              channel_active;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN_ADD,
		ST_LEN_CHK,
		ST_PH_ADD,
		ST_PH_SUB,
		ST_ENV_ADD,
		ST_ENV_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		state_t step;
		logic   accept;
		logic   trig;
		logic   len_we;
		logic   chan_off;
		logic   ph_we;
		logic   shift_en;
		logic   env_we;
		logic   vol_step;
		logic   load_out;
	} ctrl_t;

	typedef struct packed {
		logic ge;
		logic chan_on;
	} stat_t;

endpackage

### rtl/lfsr_noise_channel_top.sv
`timescale 1ns / 1ps
// One request at a time. Trigger, or tick while off: the done state loads the result.
// Tick while on: length add and check, phase add, phase subtracts for n = LFSR shifts due;
// each shift is one pass of the shared add/subtract unit over the noise phase.
// envelope add and check follow unless the envelope period is 0. A length timeout ends
// the tick at the length check. A stalled earlier result adds its stall.
// Reset: channel off, volume and timers 0, LFSR 0x7FFF, configuration registers 0.
module lfsr_noise_channel_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lnc_pkg::ADDR_W-1:0] paddr,
	input  logic [lnc_pkg::DATA_W-1:0] pwdata,
	output logic [lnc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  lnc_pkg::cmd_t              cmd,
	output logic                       res_valid,
	input  logic                       res_stall,
	output lnc_pkg::res_t              res
);

	lnc_pkg::cfg_t  cfg;
	lnc_pkg::ctrl_t ctrl;
	lnc_pkg::stat_t stat;

	lnc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lnc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_opcode (cmd.opcode),
		.cmd_stall  (cmd_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.cfg        (cfg),
		.stat       (stat),
		.ctrl       (ctrl)
	);

	lnc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.ctrl   (ctrl),
		.stat   (stat),
		.res    (res)
	);

endmodule

### rtl/lnc_cfg.sv
`timescale 1ns / 1ps
module lnc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lnc_pkg::ADDR_W-1:0] paddr,
	input  logic [lnc_pkg::DATA_W-1:0] pwdata,
	output logic [lnc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output lnc_pkg::cfg_t              cfg
);

	lnc_pkg::cfg_t     cfg_q;
	lnc_pkg::reg_idx_t idx;
	logic              wr;

	assign idx    = lnc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				lnc_pkg::REG_LENGTH_LOAD:       cfg_q.length_load       <= pwdata[5:0];
				lnc_pkg::REG_LENGTH_ENABLE:     cfg_q.length_enable     <= pwdata[0];
				lnc_pkg::REG_START_VOLUME:      cfg_q.start_volume      <= pwdata[3:0];
				lnc_pkg::REG_ENVELOPE_INCREASE: cfg_q.envelope_increase <= pwdata[0];
				lnc_pkg::REG_ENVELOPE_PERIOD:   cfg_q.envelope_period   <= pwdata[2:0];
				lnc_pkg::REG_CLOCK_SHIFT:       cfg_q.clock_shift       <= pwdata[3:0];
				lnc_pkg::REG_NARROW_MODE:       cfg_q.narrow_mode       <= pwdata[0];
				lnc_pkg::REG_DIVISOR_CODE:      cfg_q.divisor_code      <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			lnc_pkg::REG_LENGTH_LOAD:       prdata[5:0] = cfg_q.length_load;
			lnc_pkg::REG_LENGTH_ENABLE:     prdata[0]   = cfg_q.length_enable;
			lnc_pkg::REG_START_VOLUME:      prdata[3:0] = cfg_q.start_volume;
			lnc_pkg::REG_ENVELOPE_INCREASE: prdata[0]   = cfg_q.envelope_increase;
			lnc_pkg::REG_ENVELOPE_PERIOD:   prdata[2:0] = cfg_q.envelope_period;
			lnc_pkg::REG_CLOCK_SHIFT:       prdata[3:0] = cfg_q.clock_shift;
			lnc_pkg::REG_NARROW_MODE:       prdata[0]   = cfg_q.narrow_mode;
			lnc_pkg::REG_DIVISOR_CODE:      prdata[2:0] = cfg_q.divisor_code;
			default: ;
		endcase
	end

endmodule

### rtl/lnc_ctrl.sv
`timescale 1ns / 1ps
module lnc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  logic           cmd_opcode,
	output logic           cmd_stall,
	output logic           res_valid,
	input  logic           res_stall,
	input  lnc_pkg::cfg_t  cfg,
	input  lnc_pkg::stat_t stat,
	output lnc_pkg::ctrl_t ctrl
);

	lnc_pkg::state_t state_q, state_d;
	logic            res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lnc_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign cmd_stall = (state_q != lnc_pkg::ST_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lnc_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd_opcode == lnc_pkg::OP_TRIGGER || !stat.chan_on) begin
						state_d = lnc_pkg::ST_DONE;
					end else begin
						state_d = lnc_pkg::ST_LEN_ADD;
					end
				end
			end
			lnc_pkg::ST_LEN_ADD: state_d = lnc_pkg::ST_LEN_CHK;
			lnc_pkg::ST_LEN_CHK: begin
				if (cfg.length_enable && !stat.ge) begin
					state_d = lnc_pkg::ST_DONE;
				end else begin
					state_d = lnc_pkg::ST_PH_ADD;
				end
			end
			lnc_pkg::ST_PH_ADD: state_d = lnc_pkg::ST_PH_SUB;
			lnc_pkg::ST_PH_SUB: begin
				if (!stat.ge) begin
					state_d = (cfg.envelope_period == '0) ? lnc_pkg::ST_DONE
					                                      : lnc_pkg::ST_ENV_ADD;
				end
			end
			lnc_pkg::ST_ENV_ADD: state_d = lnc_pkg::ST_ENV_CHK;
			lnc_pkg::ST_ENV_CHK: state_d = lnc_pkg::ST_DONE;
			lnc_pkg::ST_DONE: begin
				if (!res_valid_q || !res_stall) begin
					state_d = lnc_pkg::ST_IDLE;
				end
			end
			default: state_d = lnc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl      = '0;
		ctrl.step = state_q;
		unique case (state_q)
			lnc_pkg::ST_IDLE: begin
				ctrl.accept = cmd_valid;
				ctrl.trig   = cmd_valid && (cmd_opcode == lnc_pkg::OP_TRIGGER);
			end
			lnc_pkg::ST_LEN_ADD: ctrl.len_we   = 1'b1;
			lnc_pkg::ST_LEN_CHK: ctrl.chan_off = cfg.length_enable && !stat.ge;
			lnc_pkg::ST_PH_ADD:  ctrl.ph_we    = 1'b1;
			lnc_pkg::ST_PH_SUB: begin
				ctrl.ph_we    = stat.ge;
				ctrl.shift_en = stat.ge;
			end
			lnc_pkg::ST_ENV_ADD: ctrl.env_we = 1'b1;
			lnc_pkg::ST_ENV_CHK: begin
				ctrl.env_we   = stat.ge;
				ctrl.vol_step = stat.ge;
			end
			lnc_pkg::ST_DONE: ctrl.load_out = !res_valid_q || !res_stall;
			default: ;
		endcase
	end

endmodule

### rtl/lnc_dp.sv
`timescale 1ns / 1ps
module lnc_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  lnc_pkg::cmd_t  cmd,
	input  lnc_pkg::cfg_t  cfg,
	input  lnc_pkg::ctrl_t ctrl,
	output lnc_pkg::stat_t stat,
	output lnc_pkg::res_t  res
);

	localparam int AW = lnc_pkg::ALU_W;

	logic                        on_q;
	logic [lnc_pkg::VOL_W-1:0]   vol_q;
	logic [lnc_pkg::LEN_W-1:0]   len_q;
	logic [lnc_pkg::ENV_W-1:0]   env_q;
	logic [lnc_pkg::PH_W-1:0]    ph_q;
	logic [lnc_pkg::LFSR_W-1:0]  sr_q;
	logic                        nb_q;
	logic [lnc_pkg::DT_W-1:0]    dt_q;
	lnc_pkg::res_t               res_q;

	logic [6:0]                  len_units;
	logic [lnc_pkg::LEN_W-1:0]   len_limit;
	logic [lnc_pkg::ENV_W-1:0]   env_limit;
	logic [6:0]                  divisor;
	logic [4:0]                  shamt;
	logic [AW-1:0]               period;

	logic [AW-1:0]               alu_a, alu_b, alu_b_eff;
	logic                        alu_sub;
	logic [AW:0]                 alu_sum;

	logic [lnc_pkg::LEN_W-1:0]   len_sat;
	logic [lnc_pkg::ENV_W-1:0]   env_sat;
	logic [lnc_pkg::LFSR_W-1:0]  sr_next;
	logic                        fb;
	logic [lnc_pkg::VOL_W-1:0]   vol_next;
	logic [4:0]                  vol_ext;

	assign len_units = 7'd64 - {1'b0, cfg.length_load};
	assign len_limit = {len_units, 15'd0};
	assign env_limit = {cfg.envelope_period, 17'd0};
	assign divisor   = (cfg.divisor_code == '0) ? 7'd8 : {cfg.divisor_code, 4'd0};
	assign shamt     = {1'b0, cfg.clock_shift} + 5'd2;
	assign period    = {{(AW-7){1'b0}}, divisor} << shamt;

	// shared add / subtract-compare unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (ctrl.step)
			lnc_pkg::ST_LEN_ADD: begin
				alu_a = AW'(len_q);
				alu_b = AW'(dt_q);
			end
			lnc_pkg::ST_LEN_CHK: begin
				alu_a   = AW'(len_limit);
				alu_b   = AW'(len_q);
				alu_sub = 1'b1;
			end
			lnc_pkg::ST_PH_ADD: begin
				alu_a = ph_q;
				alu_b = AW'(dt_q);
			end
			lnc_pkg::ST_PH_SUB: begin
				alu_a   = ph_q;
				alu_b   = period;
				alu_sub = 1'b1;
			end
			lnc_pkg::ST_ENV_ADD: begin
				alu_a = AW'(env_q);
				alu_b = AW'(dt_q);
			end
			lnc_pkg::ST_ENV_CHK: begin
				alu_a   = AW'(env_q);
				alu_b   = AW'(env_limit);
				alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
	assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b_eff} + (AW+1)'(alu_sub);

	assign stat.ge      = alu_sum[AW];
	assign stat.chan_on = on_q;

	assign len_sat = (|alu_sum[AW-1:lnc_pkg::LEN_W]) ? '1 : alu_sum[lnc_pkg::LEN_W-1:0];
	assign env_sat = (|alu_sum[AW-1:lnc_pkg::ENV_W]) ? '1 : alu_sum[lnc_pkg::ENV_W-1:0];

	always_comb begin
		fb      = sr_q[0] ^ sr_q[1];
		sr_next = {fb, sr_q[lnc_pkg::LFSR_W-1:1]};
		if (cfg.narrow_mode) begin
			sr_next[6] = fb;
		end
	end

	always_comb begin
		vol_next = vol_q;
		if (cfg.envelope_increase) begin
			if (vol_q != lnc_pkg::VOL_MAX) vol_next = vol_q + 4'd1;
		end else begin
			if (vol_q != '0) vol_next = vol_q - 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q  <= 1'b0;
			vol_q <= '0;
			len_q <= '0;
			env_q <= '0;
			ph_q  <= '0;
			sr_q  <= lnc_pkg::LFSR_RESET;
			nb_q  <= 1'b0;
		end else begin
			if (ctrl.trig) begin
				on_q  <= 1'b1;
				vol_q <= cfg.start_volume;
				len_q <= '0;
				env_q <= '0;
			end
			if (ctrl.len_we) len_q <= len_sat;
			if (ctrl.chan_off) on_q <= 1'b0;
			if (ctrl.ph_we) ph_q <= alu_sum[AW-1:0];
			if (ctrl.shift_en) begin
				sr_q <= sr_next;
				nb_q <= ~sr_q[0];
			end
			if (ctrl.env_we) begin
				env_q <= (ctrl.step == lnc_pkg::ST_ENV_ADD) ? env_sat
				                                            : alu_sum[lnc_pkg::ENV_W-1:0];
			end
			if (ctrl.vol_step) vol_q <= vol_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			dt_q <= cmd.double_speed ? {1'b0, cmd.cycles} : {cmd.cycles, 1'b0};
		end
	end

	assign vol_ext = {1'b0, vol_q};

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			res_q.channel_active <= on_q;
			if (!on_q) begin
				res_q.sample <= '0;
			end else if (!nb_q) begin
				res_q.sample <= $signed(vol_ext);
			end else begin
				res_q.sample <= $signed(5'd0 - vol_ext);
			end
		end
	end

	assign res = res_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam int DRAIN_CYCLES = 64;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [lnc_pkg::ADDR_W-1:0]   paddr = '0;
	logic [lnc_pkg::DATA_W-1:0]   pwdata = '0;
	logic [lnc_pkg::DATA_W-1:0]   prdata;
	logic                         pready;
	logic                         cmd_valid = 1'b0;
	logic                         cmd_stall;
	lnc_pkg::cmd_t                cmd = '0;
	logic                         res_valid;
	logic                         res_stall = 1'b0;
	lnc_pkg::res_t                res;

	lfsr_noise_channel_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// channel model state and register copy
	lnc_pkg::cfg_t   cfg_m = '0;
	logic            ch_on = 1'b0;
	logic [3:0]      ch_vol = '0;
	int unsigned     len_elapsed = 0;
	int unsigned     env_elapsed = 0;
	int unsigned     noise_ph = 0;
	logic [14:0]     lfsr_q = 15'h7FFF;
	logic            noise_q = 1'b0;

	lnc_pkg::cmd_t pending_cmds[$];
	lnc_pkg::res_t expected_res[$];
	int   mismatches = 0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned sat_sum(int unsigned a, int unsigned b, int unsigned lim);
		int unsigned s;
		s = a + b;
		return (s > lim) ? lim : s;
	endfunction

	task automatic shift_noise();
		logic out_bit;
		logic fb;
		out_bit = lfsr_q[0];
		lfsr_q = lfsr_q >> 1;
		fb = out_bit ^ lfsr_q[0];
		lfsr_q[14] = fb;
		if (cfg_m.narrow_mode)
			lfsr_q[6] = fb;
		noise_q = ~out_bit;
	endtask

	task automatic advance_channel(input int unsigned dt);
		int unsigned r;
		int unsigned period;
		int unsigned n;
		int unsigned env;
		if (!ch_on)
			return;
		len_elapsed = sat_sum(len_elapsed, dt, 32'h3F_FFFF);
		if (cfg_m.length_enable && len_elapsed > (64 - cfg_m.length_load) * 32768) begin
			ch_on = 1'b0;
			return;
		end
		r = (cfg_m.divisor_code == 0) ? 8 : 16 * cfg_m.divisor_code;
		period = 2 * r * (1 << (cfg_m.clock_shift + 1));
		noise_ph = noise_ph + dt;
		n = noise_ph / period;
		noise_ph = noise_ph - n * period;
		repeat (n) shift_noise();
		if (cfg_m.envelope_period != 0) begin
			env = cfg_m.envelope_period * 131072;
			env_elapsed = sat_sum(env_elapsed, dt, 32'hF_FFFF);
			if (env_elapsed >= env) begin
				if (cfg_m.envelope_increase) begin
					if (ch_vol != lnc_pkg::VOL_MAX)
						ch_vol = ch_vol + 1;
				end else begin
					if (ch_vol != 0)
						ch_vol = ch_vol - 1;
				end
				env_elapsed = env_elapsed - env;
			end
		end
	endtask

	task automatic predict_sample(input lnc_pkg::cmd_t c);
		lnc_pkg::res_t e;
		if (c.opcode == lnc_pkg::OP_TRIGGER) begin
			ch_on = 1'b1;
			ch_vol = cfg_m.start_volume;
			len_elapsed = 0;
			env_elapsed = 0;
		end else begin
			advance_channel(c.double_speed ? c.cycles : 2 * c.cycles);
		end
		e.channel_active = ch_on;
		if (!ch_on)
			e.sample = '0;
		else if (!noise_q)
			e.sample = {1'b0, ch_vol};
		else
			e.sample = 5'd0 - {1'b0, ch_vol};
		expected_res.push_back(e);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				predict_sample(cmd);
			if (!cmd_valid || !cmd_stall) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		lnc_pkg::res_t e;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					$display("%0t: unexpected result sample %0d active %0b", $time,
						$signed(res.sample), res.channel_active);
					mismatches++;
				end else begin
					e = expected_res.pop_front();
					if (res.sample !== e.sample) begin
						$display("%0t: sample expected %0d actual %0d", $time,
							$signed(e.sample), $signed(res.sample));
						mismatches++;
					end
					if (res.channel_active !== e.channel_active) begin
						$display("%0t: channel_active expected %0b actual %0b", $time,
							e.channel_active, res.channel_active);
						mismatches++;
					end
				end
			end
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic apb_write(input lnc_pkg::reg_idx_t idx, input logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			lnc_pkg::REG_LENGTH_LOAD:       cfg_m.length_load = val[5:0];
			lnc_pkg::REG_LENGTH_ENABLE:     cfg_m.length_enable = val[0];
			lnc_pkg::REG_START_VOLUME:      cfg_m.start_volume = val[3:0];
			lnc_pkg::REG_ENVELOPE_INCREASE: cfg_m.envelope_increase = val[0];
			lnc_pkg::REG_ENVELOPE_PERIOD:   cfg_m.envelope_period = val[2:0];
			lnc_pkg::REG_CLOCK_SHIFT:       cfg_m.clock_shift = val[3:0];
			lnc_pkg::REG_NARROW_MODE:       cfg_m.narrow_mode = val[0];
			lnc_pkg::REG_DIVISOR_CODE:      cfg_m.divisor_code = val[2:0];
			default: ;
		endcase
	endtask

	task automatic load_channel_cfg(input lnc_pkg::cfg_t c);
		apb_write(lnc_pkg::REG_LENGTH_LOAD, 8'(c.length_load));
		apb_write(lnc_pkg::REG_LENGTH_ENABLE, 8'(c.length_enable));
		apb_write(lnc_pkg::REG_START_VOLUME, 8'(c.start_volume));
		apb_write(lnc_pkg::REG_ENVELOPE_INCREASE, 8'(c.envelope_increase));
		apb_write(lnc_pkg::REG_ENVELOPE_PERIOD, 8'(c.envelope_period));
		apb_write(lnc_pkg::REG_CLOCK_SHIFT, 8'(c.clock_shift));
		apb_write(lnc_pkg::REG_NARROW_MODE, 8'(c.narrow_mode));
		apb_write(lnc_pkg::REG_DIVISOR_CODE, 8'(c.divisor_code));
	endtask

	task automatic wait_quiet();
		while (pending_cmds.size() != 0 || cmd_valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int snd, input int rcv);
		send_idle_pct = snd;
		stall_pct = rcv;
	endtask

	function automatic lnc_pkg::cmd_t make_cmd(input logic op, input int cyc, input logic dbl);
		lnc_pkg::cmd_t c;
		c.opcode = op;
		c.cycles = 8'(cyc);
		c.double_speed = dbl;
		return c;
	endfunction

	// long ticks for long_pct percent of calls so the timers get somewhere; the rest fully random
	function automatic lnc_pkg::cmd_t rand_tick(input int long_pct);
		if ($urandom_range(99) < long_pct)
			return make_cmd(lnc_pkg::OP_TICK, $urandom_range(255, 224), 1'b0);
		return make_cmd(lnc_pkg::OP_TICK, $urandom_range(255, 0), 1'($urandom_range(1, 0)));
	endfunction

	task automatic push_burst(input int n_ticks, input int long_pct);
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TRIGGER, $urandom_range(255, 0),
			1'($urandom_range(1, 0))));
		repeat (n_ticks) pending_cmds.push_back(rand_tick(long_pct));
	endtask

	task automatic push_noise(input int n);
		repeat (n) begin
			if ($urandom_range(3) == 0)
				pending_cmds.push_back(make_cmd(lnc_pkg::OP_TRIGGER, $urandom_range(255, 0),
					1'($urandom_range(1, 0))));
			else
				pending_cmds.push_back(rand_tick(0));
		end
	endtask

	function automatic lnc_pkg::cfg_t rand_cfg();
		lnc_pkg::cfg_t c;
		c = lnc_pkg::cfg_t'($urandom);
		return c;
	endfunction

	initial begin
		lnc_pkg::cfg_t c;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ticks while off, trigger with volume 0
		set_idling(13, 13);
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 255, 1'b0));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 0, 1'b1));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TRIGGER, 255, 1'b1));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 0, 1'b0));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 255, 1'b0));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 255, 1'b1));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 1, 1'b0));
		wait_quiet();

		// shortest noise period, narrow feedback, full volume
		c = '0;
		c.start_volume = 4'hF;
		c.envelope_increase = 1'b1;
		c.narrow_mode = 1'b1;
		load_channel_cfg(c);
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TRIGGER, 0, 1'b0));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 255, 1'b0));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 16, 1'b0));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 17, 1'b1));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 0, 1'b1));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 128, 1'b0));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 255, 1'b1));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TRIGGER, 170, 1'b1));
		pending_cmds.push_back(make_cmd(lnc_pkg::OP_TICK, 85, 1'b0));
		wait_quiet();

		// longest period, shortest length: timeouts
		set_idling(0, 0);
		c = '0;
		c.length_load = 6'd63;
		c.length_enable = 1'b1;
		c.start_volume = 4'hF;
		c.clock_shift = 4'hF;
		c.divisor_code = 3'd7;
		load_channel_cfg(c);
		push_burst(75, 90);
		push_noise(4);
		wait_quiet();

		// drop to the shortest period; envelope rises into saturation
		set_idling(75, 0);
		c = rand_cfg();
		c.length_enable = 1'b0;
		c.start_volume = 4'hF;
		c.envelope_increase = 1'b1;
		c.envelope_period = 3'd1;
		c.clock_shift = 4'h0;
		c.narrow_mode = 1'b1;
		c.divisor_code = 3'd0;
		load_channel_cfg(c);
		push_burst(295, 97);
		wait_quiet();

		// random settings with a short length
		set_idling(0, 75);
		c = rand_cfg();
		c.length_enable = 1'b1;
		c.length_load = 6'($urandom_range(63, 62));
		load_channel_cfg(c);
		push_burst(40, 70);
		push_noise(6);
		wait_quiet();

		// envelope falls into saturation at zero
		set_idling(13, 13);
		c = rand_cfg();
		c.length_enable = 1'b0;
		c.start_volume = 4'h0;
		c.envelope_increase = 1'b0;
		c.envelope_period = 3'd1;
		c.clock_shift = 4'($urandom_range(3, 0));
		load_channel_cfg(c);
		push_burst(295, 97);
		wait_quiet();

		// random settings, clock shift at most 6; sender holds off until all results are back
		set_idling(0, 75);
		c = rand_cfg();
		c.clock_shift = 4'($urandom_range(6, 0));
		load_channel_cfg(c);
		push_burst(20, 60);
		push_noise(5);
		wait_quiet();
		set_idling(0, 0);
		push_burst(20, 60);
		push_noise(5);
		wait_quiet();

		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### sim.f
rtl/lnc_pkg.sv
rtl/lnc_cfg.sv
rtl/lnc_ctrl.sv
rtl/lnc_dp.sv
rtl/lfsr_noise_channel_top.sv
tb/tb.sv
